// ===== hw/rtl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// Shared constants, types and calendar tables for the date arithmetic block.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

   localparam logic [11:0] FirstYear   = 12'd1970;
   localparam logic [11:0] LastYear    = 12'd2099;
   localparam logic [15:0] LastIndex   = 16'd47481;
   localparam logic [8:0]  DaysPerYear = 9'd365;
   localparam logic [10:0] DaysPerQuad = 11'd1461;
   localparam logic [11:0] QuadRecip   = 12'd2870;
   localparam int          QuadShift   = 22;

   localparam logic [3:0] MonthJan = 4'd1;
   localparam logic [3:0] MonthFeb = 4'd2;
   localparam logic [3:0] MonthMar = 4'd3;
   localparam logic [3:0] MonthApr = 4'd4;
   localparam logic [3:0] MonthMay = 4'd5;
   localparam logic [3:0] MonthJun = 4'd6;
   localparam logic [3:0] MonthJul = 4'd7;
   localparam logic [3:0] MonthAug = 4'd8;
   localparam logic [3:0] MonthSep = 4'd9;
   localparam logic [3:0] MonthOct = 4'd10;
   localparam logic [3:0] MonthNov = 4'd11;
   localparam logic [3:0] MonthDec = 4'd12;

   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } date_type;

   typedef struct packed {
      logic [7:0] year_off;
      logic [8:0] doy;
      logic       leap;
   } year_split_type;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         MonthJan, MonthMar, MonthMay, MonthJul,
         MonthAug, MonthOct, MonthDec:            len = 5'd31;
         MonthApr, MonthJun, MonthSep, MonthNov:  len = 5'd30;
         MonthFeb:                                len = leap ? 5'd29 : 5'd28;
         default:                                 len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
      logic [8:0] start;
      case (month)
         MonthJan: start = 9'd0;
         MonthFeb: start = 9'd31;
         MonthMar: start = 9'd59;
         MonthApr: start = 9'd90;
         MonthMay: start = 9'd120;
         MonthJun: start = 9'd151;
         MonthJul: start = 9'd181;
         MonthAug: start = 9'd212;
         MonthSep: start = 9'd243;
         MonthOct: start = 9'd273;
         MonthNov: start = 9'd304;
         MonthDec: start = 9'd334;
         default:  start = 9'd0;
      endcase
      if (leap && (month inside {[MonthMar:MonthDec]})) begin
         start = start + 9'd1;
      end
      return start;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cda_if.sv =====
// ----------------------------------------------------------------------------
// cda_req_if / cda_rsp_if
// Valid/ready channels carrying date requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cda_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         a_day;
   logic [3:0]         a_month;
   logic [11:0]        a_year;
   logic [4:0]         b_day;
   logic [3:0]         b_month;
   logic [11:0]        b_year;
   logic signed [16:0] offset_days;

   modport source (output valid, a_day, a_month, a_year, b_day, b_month, b_year,
                   offset_days, input ready);
   modport sink   (input valid, a_day, a_month, a_year, b_day, b_month, b_year,
                   offset_days, output ready);
endinterface

interface cda_rsp_if;
   logic               valid;
   logic               ready;
   logic               a_valid;
   logic               b_valid;
   logic [4:0]         sum_day;
   logic [3:0]         sum_month;
   logic [11:0]        sum_year;
   logic               sum_out_of_range;
   logic signed [16:0] difference_days;

   modport source (output valid, a_valid, b_valid, sum_day, sum_month, sum_year,
                   sum_out_of_range, difference_days, input ready);
   modport sink   (input valid, a_valid, b_valid, sum_day, sum_month, sum_year,
                   sum_out_of_range, difference_days, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cda_date_index.sv =====
// ----------------------------------------------------------------------------
// cda_date_index
// Check one calendar date and convert it to a day count from 1970-01-01.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_date_index (
   input  var cda_pkg::date_type date,
   output logic                  date_valid,
   output logic [15:0]           index
);

   logic       in_range;
   logic [7:0] year_off;
   logic       leap;
   logic [4:0] dlen;

   always_comb begin
      in_range   = (date.year >= cda_pkg::FirstYear) && (date.year <= cda_pkg::LastYear)
                   && (date.month inside {[cda_pkg::MonthJan:cda_pkg::MonthDec]});
      year_off   = 8'(date.year - cda_pkg::FirstYear);
      leap       = (date.year[1:0] == 2'b00);
      dlen       = cda_pkg::month_len(date.month, leap);
      date_valid = in_range && (date.day != 5'd0) && (date.day <= dlen);
      if (date_valid) begin
         index = 16'(year_off) * 16'(cda_pkg::DaysPerYear)
               + 16'((year_off + 8'd1) >> 2)
               + 16'(cda_pkg::month_start(date.month, leap))
               + 16'(date.day) - 16'd1;
      end else begin
         index = 16'd0;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cda_year_split.sv =====
// ----------------------------------------------------------------------------
// cda_year_split
// Correct the four-year block estimate and split a day count into year and
// day of year.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_year_split (
   input  var logic [15:0]             sum_index,
   input  var logic [5:0]              quad_est,
   output cda_pkg::year_split_type     split
);

   logic [15:0] quad_base;
   logic [11:0] rem_raw;
   logic        quad_fix;
   logic [5:0]  quad;
   logic [10:0] rem;
   logic [1:0]  year_in_quad;
   logic [8:0]  doy;

   always_comb begin
      quad_base = 16'(quad_est) * 16'(cda_pkg::DaysPerQuad);
      rem_raw   = 12'(sum_index - quad_base);
      quad_fix  = (rem_raw >= 12'(cda_pkg::DaysPerQuad));
      quad      = quad_fix ? quad_est + 6'd1 : quad_est;
      rem       = quad_fix ? 11'(rem_raw - 12'(cda_pkg::DaysPerQuad)) : 11'(rem_raw);
      if (rem < 11'd365) begin
         year_in_quad = 2'd0;
         doy          = 9'(rem);
      end else if (rem < 11'd730) begin
         year_in_quad = 2'd1;
         doy          = 9'(rem - 11'd365);
      end else if (rem < 11'd1096) begin
         year_in_quad = 2'd2;
         doy          = 9'(rem - 11'd730);
      end else begin
         year_in_quad = 2'd3;
         doy          = 9'(rem - 11'd1096);
      end
      split.year_off = 8'({quad, year_in_quad});
      split.doy      = doy;
      split.leap     = (year_in_quad == 2'd2);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cda_month_split.sv =====
// ----------------------------------------------------------------------------
// cda_month_split
// Turn a year offset and day of year into a calendar date.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_month_split (
   input  var cda_pkg::year_split_type split,
   output cda_pkg::date_type           date
);

   logic [3:0] month;
   logic [8:0] start;

   always_comb begin
      month = cda_pkg::MonthJan;
      for (int i = 2; i <= 12; i++) begin
         if (split.doy >= cda_pkg::month_start(4'(i), split.leap)) begin
            month = month + 4'd1;
         end
      end
      start      = cda_pkg::month_start(month, split.leap);
      date.month = month;
      date.day   = 5'(split.doy - start + 9'd1);
      date.year  = cda_pkg::FirstYear + 12'(split.year_off);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_date_arithmetic.sv =====
// ----------------------------------------------------------------------------
// calendar_date_arithmetic
// Gregorian date shift and day difference, five-stage pipeline.
//
//   Channel   Dir  Carries
//   req_chan  in   dates A and B, signed day offset
//   rsp_chan  out  valid flags, shifted A, saturation flag, A minus B in days
//
// One request per cycle unless a stalled result holds the pipeline.
// Stages: date check and day count, shift and saturate, block estimate
// multiply, year split, month split into the output register.
// A stalled result holds every stage whose successor is full; a stage
// with a free slot downstream keeps moving, so no bubble is left.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_arithmetic (
   input  wire        clock,
   input  wire        reset,
   cda_req_if.sink    req_chan,
   cda_rsp_if.source  rsp_chan
);

   logic adv1, adv2, adv3, adv4, adv5;

   // stage 1: check and index
   cda_pkg::date_type  a_date, b_date;
   logic               a_ok, b_ok;
   logic [15:0]        a_idx, b_idx;

   logic               v1_ff;
   logic               av1_ff, bv1_ff;
   logic [15:0]        a_index1_ff, b_index1_ff;
   logic signed [16:0] offset1_ff;

   // stage 2: shift and difference
   logic signed [17:0] sum_raw;
   logic [15:0]        sum_index_in;
   logic               oor_in;
   logic signed [16:0] diff_in;

   logic               v2_ff;
   logic               av2_ff, bv2_ff, oor2_ff;
   logic [15:0]        sum_index2_ff;
   logic signed [16:0] diff2_ff;

   // stage 3: four-year block estimate
   logic [27:0]        quad_prod;
   logic [5:0]         quad_est_in;

   logic               v3_ff;
   logic               av3_ff, bv3_ff, oor3_ff;
   logic [15:0]        sum_index3_ff;
   logic [5:0]         quad_est3_ff;
   logic signed [16:0] diff3_ff;

   // stage 4: year split
   cda_pkg::year_split_type split_in;

   logic                    v4_ff;
   logic                    av4_ff, bv4_ff, oor4_ff;
   cda_pkg::year_split_type split4_ff;
   logic signed [16:0]      diff4_ff;

   // stage 5: month split
   cda_pkg::date_type  date_in;

   logic               v5_ff;
   logic               av5_ff, bv5_ff, oor5_ff;
   cda_pkg::date_type  date5_ff;
   logic signed [16:0] diff5_ff;

   assign adv5 = !v5_ff || rsp_chan.ready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_chan.ready = adv1;

   assign a_date = '{day: req_chan.a_day, month: req_chan.a_month, year: req_chan.a_year};
   assign b_date = '{day: req_chan.b_day, month: req_chan.b_month, year: req_chan.b_year};

   cda_date_index u_a_index (
      .date       (a_date),
      .date_valid (a_ok),
      .index      (a_idx)
   );

   cda_date_index u_b_index (
      .date       (b_date),
      .date_valid (b_ok),
      .index      (b_idx)
   );

   always_comb begin
      sum_raw = $signed({2'b00, a_index1_ff}) + $signed({offset1_ff[16], offset1_ff});
      diff_in = $signed({1'b0, a_index1_ff}) - $signed({1'b0, b_index1_ff});
      if (sum_raw < 18'sd0) begin
         sum_index_in = 16'd0;
         oor_in       = 1'b1;
      end else if (sum_raw > $signed({2'b00, cda_pkg::LastIndex})) begin
         sum_index_in = cda_pkg::LastIndex;
         oor_in       = 1'b1;
      end else begin
         sum_index_in = sum_raw[15:0];
         oor_in       = 1'b0;
      end
   end

   assign quad_prod   = 28'(sum_index2_ff) * 28'(cda_pkg::QuadRecip);
   assign quad_est_in = 6'(quad_prod >> cda_pkg::QuadShift);

   cda_year_split u_year_split (
      .sum_index (sum_index3_ff),
      .quad_est  (quad_est3_ff),
      .split     (split_in)
   );

   cda_month_split u_month_split (
      .split (split4_ff),
      .date  (date_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_chan.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_chan.valid) begin
         av1_ff      <= a_ok;
         bv1_ff      <= b_ok;
         a_index1_ff <= a_idx;
         b_index1_ff <= b_idx;
         offset1_ff  <= req_chan.offset_days;
      end
      if (adv2 && v1_ff) begin
         av2_ff        <= av1_ff;
         bv2_ff        <= bv1_ff;
         oor2_ff       <= oor_in;
         sum_index2_ff <= sum_index_in;
         diff2_ff      <= diff_in;
      end
      if (adv3 && v2_ff) begin
         av3_ff        <= av2_ff;
         bv3_ff        <= bv2_ff;
         oor3_ff       <= oor2_ff;
         sum_index3_ff <= sum_index2_ff;
         quad_est3_ff  <= quad_est_in;
         diff3_ff      <= diff2_ff;
      end
      if (adv4 && v3_ff) begin
         av4_ff    <= av3_ff;
         bv4_ff    <= bv3_ff;
         oor4_ff   <= oor3_ff;
         split4_ff <= split_in;
         diff4_ff  <= diff3_ff;
      end
      if (adv5 && v4_ff) begin
         av5_ff   <= av4_ff;
         bv5_ff   <= bv4_ff;
         oor5_ff  <= oor4_ff;
         date5_ff <= date_in;
         diff5_ff <= diff4_ff;
      end
   end

   assign rsp_chan.valid            = v5_ff;
   assign rsp_chan.a_valid          = av5_ff;
   assign rsp_chan.b_valid          = bv5_ff;
   assign rsp_chan.sum_day          = date5_ff.day;
   assign rsp_chan.sum_month        = date5_ff.month;
   assign rsp_chan.sum_year         = date5_ff.year;
   assign rsp_chan.sum_out_of_range = oor5_ff;
   assign rsp_chan.difference_days  = diff5_ff;

   a_invalid_epoch : assert property (@(posedge clock) disable iff (reset)
      v1_ff && !av1_ff |-> a_index1_ff == 16'd0)
      else $error("invalid first date did not map to the epoch");

   a_sum_in_range : assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> sum_index2_ff <= cda_pkg::LastIndex)
      else $error("saturated day count beyond last date");

   a_doy_bound : assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (split4_ff.doy < 9'd365) || (split4_ff.leap && split4_ff.doy == 9'd365))
      else $error("day of year exceeds year length");

   a_rsp_date_sane : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.sum_year >= cda_pkg::FirstYear
                         && rsp_chan.sum_year <= cda_pkg::LastYear
                         && rsp_chan.sum_month >= cda_pkg::MonthJan
                         && rsp_chan.sum_month <= cda_pkg::MonthDec
                         && rsp_chan.sum_day != 5'd0)
      else $error("result date outside calendar range");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid straight after reset");

endmodule

`default_nettype wire

// ===== test/tb_calendar_date_arithmetic.sv =====
// ----------------------------------------------------------------------------
// tb_calendar_date_arithmetic
// Self-checking bench for the Gregorian date shift and day difference block.
// A short table of hand-picked requests goes first. Rows whose results are
// obvious carry them typed in, and the rest are checked by a behavioural
// calendar model. About seventeen hundred random requests follow: mostly
// well-formed dates with random content, some broken dates, and offsets
// aimed at both ends of the range. Both channels idle at random, the result
// side holds off once for a long stretch, and the request side waits for
// the pipeline to drain between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_calendar_date_arithmetic;

   localparam int CycleLimit   = 200000;
   localparam int PhaseItems   = 560;
   localparam int LongHold     = 80;
   localparam int DrainCycles  = 20;
   localparam int NumDirected  = 25;
   localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam cda_pkg::date_type EpochDate = '{5'd1, 4'd1, 12'd1970};

   typedef struct packed {
      cda_pkg::date_type  a;
      cda_pkg::date_type  b;
      logic signed [16:0] offset_days;
   } date_req_type;

   typedef struct packed {
      logic               a_valid;
      logic               b_valid;
      cda_pkg::date_type  sum;
      logic               sum_out_of_range;
      logic signed [16:0] difference_days;
   } date_rsp_type;

   typedef struct packed {
      cda_pkg::date_type  a;
      cda_pkg::date_type  b;
      logic signed [16:0] offset_days;
      logic               known;
      date_rsp_type       want;
   } directed_row_type;

   logic         clock;
   logic         reset;
   int           error_count;
   int           cycle_count;
   int           result_count;
   int           send_idle_pct;
   int           rsp_stall_pct;
   int           hold_requests;
   int           hold_served;
   int           hold_left;
   logic         fixed_known;
   date_rsp_type fixed_result;
   date_rsp_type due_results [$];

   cda_req_if req_chan ();
   cda_rsp_if rsp_chan ();

   calendar_date_arithmetic dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   directed_row_type directed_rows [NumDirected] = '{
      '{'{1, 1, 1970}, '{1, 1, 1970}, 0, 1, '{1, 1, '{1, 1, 1970}, 0, 0}},
      '{'{31, 12, 2099}, '{1, 1, 1970}, 0, 1, '{1, 1, '{31, 12, 2099}, 0, 47481}},
      '{'{1, 1, 1970}, '{31, 12, 2099}, 0, 1, '{1, 1, '{1, 1, 1970}, 0, -47481}},
      '{'{1, 1, 1970}, '{1, 1, 1970}, 1, 1, '{1, 1, '{2, 1, 1970}, 0, 0}},
      '{'{1, 1, 1970}, '{1, 1, 1970}, -1, 1, '{1, 1, '{1, 1, 1970}, 1, 0}},
      '{'{31, 12, 2099}, '{1, 1, 1970}, 1, 1, '{1, 1, '{31, 12, 2099}, 1, 47481}},
      '{'{1, 1, 1970}, '{1, 1, 1970}, 65535, 1, '{1, 1, '{31, 12, 2099}, 1, 0}},
      '{'{31, 12, 2099}, '{1, 1, 1970}, -65536, 1, '{1, 1, '{1, 1, 1970}, 1, 47481}},
      '{'{1, 1, 1970}, '{1, 1, 1970}, 47481, 1, '{1, 1, '{31, 12, 2099}, 0, 0}},
      '{'{31, 12, 2099}, '{1, 1, 1970}, -47481, 1, '{1, 1, '{1, 1, 1970}, 0, 47481}},
      '{'{10, 0, 2000}, '{1, 1, 1970}, 0, 1, '{0, 1, '{1, 1, 1970}, 0, 0}},
      '{'{10, 13, 2000}, '{1, 1, 1970}, 5, 1, '{0, 1, '{6, 1, 1970}, 0, 0}},
      '{'{0, 6, 2010}, '{1, 1, 1970}, 0, 1, '{0, 1, '{1, 1, 1970}, 0, 0}},
      '{'{31, 4, 2020}, '{1, 1, 1970}, 0, 1, '{0, 1, '{1, 1, 1970}, 0, 0}},
      '{'{29, 2, 2001}, '{1, 1, 1970}, 0, 1, '{0, 1, '{1, 1, 1970}, 0, 0}},
      '{'{29, 2, 2100}, '{1, 1, 1970}, 0, 1, '{0, 1, '{1, 1, 1970}, 0, 0}},
      '{'{31, 12, 1969}, '{1, 1, 1970}, 0, 1, '{0, 1, '{1, 1, 1970}, 0, 0}},
      '{'{0, 0, 0}, '{31, 15, 4095}, 0, 1, '{0, 0, '{1, 1, 1970}, 0, 0}},
      '{'{1, 1, 1970}, '{29, 2, 1900}, 0, 1, '{1, 0, '{1, 1, 1970}, 0, 0}},
      '{'{29, 2, 2000}, '{1, 1, 1970}, 0, 0, '0},
      '{'{29, 2, 2096}, '{1, 3, 2096}, -1, 0, '0},
      '{'{31, 12, 1999}, '{1, 1, 2000}, 1, 0, '0},
      '{'{28, 2, 2000}, '{1, 1, 1970}, 1, 0, '0},
      '{'{1, 3, 2004}, '{28, 2, 1971}, -1, 0, '0},
      '{'{15, 6, 2050}, '{15, 6, 2049}, 12345, 0, '0}
   };

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_of_month(input int unsigned m, input int unsigned y);
      if (m < 1 || m > 12) begin
         return 0;
      end
      if (m == 2 && leap_year(y)) begin
         return 29;
      end
      return MonthDays[m - 1];
   endfunction

   function automatic bit date_ok(input cda_pkg::date_type dt);
      if (dt.year < cda_pkg::FirstYear || dt.year > cda_pkg::LastYear
          || dt.month < 1 || dt.month > 12) begin
         return 1'b0;
      end
      return (dt.day >= 1) && (int'(dt.day) <= days_of_month(dt.month, dt.year));
   endfunction

   function automatic int epoch_day(input cda_pkg::date_type dt);
      int n;
      n = 0;
      for (int unsigned y = cda_pkg::FirstYear; y < dt.year; y++) begin
         n += leap_year(y) ? 366 : 365;
      end
      for (int unsigned m = 1; m < dt.month; m++) begin
         n += days_of_month(m, dt.year);
      end
      return n + int'(dt.day) - 1;
   endfunction

   function automatic cda_pkg::date_type calendar_date(input int n);
      int unsigned       y;
      int unsigned       m;
      int                left;
      cda_pkg::date_type dt;
      y    = cda_pkg::FirstYear;
      m    = 1;
      left = n;
      while (y < cda_pkg::LastYear && left >= (leap_year(y) ? 366 : 365)) begin
         left -= leap_year(y) ? 366 : 365;
         y++;
      end
      while (m < 12 && left >= days_of_month(m, y)) begin
         left -= days_of_month(m, y);
         m++;
      end
      dt.day   = 5'(left + 1);
      dt.month = 4'(m);
      dt.year  = 12'(y);
      return dt;
   endfunction

   function automatic date_rsp_type shift_and_gap(input date_req_type r);
      date_rsp_type      res;
      cda_pkg::date_type a;
      cda_pkg::date_type b;
      int                na;
      int                nb;
      int                s;
      res.a_valid          = date_ok(r.a);
      res.b_valid          = date_ok(r.b);
      a                    = res.a_valid ? r.a : EpochDate;
      b                    = res.b_valid ? r.b : EpochDate;
      na                   = epoch_day(a);
      nb                   = epoch_day(b);
      s                    = na + int'($signed(r.offset_days));
      res.sum_out_of_range = 1'b0;
      if (s < 0) begin
         s                    = 0;
         res.sum_out_of_range = 1'b1;
      end
      if (s > int'(cda_pkg::LastIndex)) begin
         s                    = int'(cda_pkg::LastIndex);
         res.sum_out_of_range = 1'b1;
      end
      res.sum             = calendar_date(s);
      res.difference_days = 17'(na - nb);
      return res;
   endfunction

   function automatic cda_pkg::date_type random_date();
      cda_pkg::date_type dt;
      int unsigned       pick;
      int unsigned       y;
      int unsigned       m;
      pick = $urandom_range(99);
      if (pick < 12) begin
         dt.day   = 5'($urandom);
         dt.month = 4'($urandom);
         dt.year  = 12'($urandom);
      end else if (pick < 22) begin
         case ($urandom_range(2))
            0:       y = 1969;
            1:       y = 2100;
            default: y = $urandom_range(2099, 1970);
         endcase
         dt.day   = 5'($urandom_range(31));
         dt.month = 4'($urandom_range(15));
         dt.year  = 12'(y);
      end else if (pick < 32) begin
         y = $urandom_range(2099, 1970);
         m = $urandom_range(12, 1);
         case ($urandom_range(3))
            0:       dt = EpochDate;
            1:       dt = '{5'd31, 4'd12, 12'd2099};
            2:       dt = '{5'd29, 4'd2, 12'(1972 + 4 * $urandom_range(31))};
            default: dt = '{5'(days_of_month(m, y)), 4'(m), 12'(y)};
         endcase
      end else begin
         y        = $urandom_range(2099, 1970);
         m        = $urandom_range(12, 1);
         dt.day   = 5'($urandom_range(days_of_month(m, y), 1));
         dt.month = 4'(m);
         dt.year  = 12'(y);
      end
      return dt;
   endfunction

   function automatic logic signed [16:0] random_offset(input int base);
      int          off;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 35) begin
         off = int'($urandom_range(800)) - 400;
      end else if (pick < 60) begin
         off = int'($urandom);
      end else if (pick < 75) begin
         off = int'($urandom_range(6)) - 3 - base;
      end else if (pick < 90) begin
         off = int'(cda_pkg::LastIndex) + int'($urandom_range(6)) - 3 - base;
      end else begin
         case ($urandom_range(4))
            0:       off = -65536;
            1:       off = 65535;
            2:       off = 0;
            3:       off = 1;
            default: off = -1;
         endcase
      end
      return 17'(off);
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] got_v,
                              input logic signed [31:0] want_v);
      if (got_v !== want_v) begin
         report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got_v, want_v));
      end
   endtask

   task automatic offer_request(input date_req_type r, input logic known,
                                input date_rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.a_day       = r.a.day;
      req_chan.a_month     = r.a.month;
      req_chan.a_year      = r.a.year;
      req_chan.b_day       = r.b.day;
      req_chan.b_month     = r.b.month;
      req_chan.b_year      = r.b.year;
      req_chan.offset_days = r.offset_days;
      fixed_known          = known;
      fixed_result         = want;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic offer_random_request();
      date_req_type r;
      int           base;
      r.a           = random_date();
      r.b           = random_date();
      base          = date_ok(r.a) ? epoch_day(r.a) : 0;
      r.offset_days = random_offset(base);
      offer_request(r, 1'b0, '0);
   endtask

   task automatic wait_for_results();
      req_chan.valid = 1'b0;
      while (due_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      report_error("timeout");
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off when the sender asks
   initial begin
      rsp_chan.ready = 1'b0;
      hold_served    = 0;
      hold_left      = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left      = LongHold - 1;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      date_req_type r;
      date_rsp_type got;
      date_rsp_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            if (fixed_known) begin
               due_results.push_back(fixed_result);
            end else begin
               r.a           = '{req_chan.a_day, req_chan.a_month, req_chan.a_year};
               r.b           = '{req_chan.b_day, req_chan.b_month, req_chan.b_year};
               r.offset_days = req_chan.offset_days;
               due_results.push_back(shift_and_gap(r));
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            got = '{rsp_chan.a_valid, rsp_chan.b_valid,
                    '{rsp_chan.sum_day, rsp_chan.sum_month, rsp_chan.sum_year},
                    rsp_chan.sum_out_of_range, rsp_chan.difference_days};
            if (due_results.size() == 0) begin
               report_error($sformatf("result %0d arrived with none expected", result_count));
            end else begin
               want = due_results.pop_front();
               check_field("a_valid", got.a_valid, want.a_valid);
               check_field("b_valid", got.b_valid, want.b_valid);
               check_field("sum_day", got.sum.day, want.sum.day);
               check_field("sum_month", got.sum.month, want.sum.month);
               check_field("sum_year", got.sum.year, want.sum.year);
               check_field("sum_out_of_range", got.sum_out_of_range, want.sum_out_of_range);
               check_field("difference_days", got.difference_days, want.difference_days);
            end
         end
      end
   end

   initial begin
      date_req_type r;
      error_count          = 0;
      result_count         = 0;
      hold_requests        = 0;
      send_idle_pct        = 21;
      rsp_stall_pct        = 74;
      fixed_known          = 1'b0;
      fixed_result         = '0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.a_day       = '0;
      req_chan.a_month     = '0;
      req_chan.a_year      = '0;
      req_chan.b_day       = '0;
      req_chan.b_month     = '0;
      req_chan.b_year      = '0;
      req_chan.offset_days = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NumDirected; i++) begin
         r.a           = directed_rows[i].a;
         r.b           = directed_rows[i].b;
         r.offset_days = directed_rows[i].offset_days;
         offer_request(r, directed_rows[i].known, directed_rows[i].want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               rsp_stall_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               rsp_stall_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               // hold results back while requests keep coming
               hold_requests++;
            end
         endcase
         for (int i = 0; i < PhaseItems; i++) begin
            offer_random_request();
         end
         wait_for_results();
      end

      repeat (DrainCycles) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/cda_pkg.sv
hw/rtl/cda_if.sv
hw/rtl/cda_date_index.sv
hw/rtl/cda_year_split.sv
hw/rtl/cda_month_split.sv
hw/rtl/calendar_date_arithmetic.sv
test/tb_calendar_date_arithmetic.sv
